/* design/acia_pkg.sv */
// shared types and command codes for the serial interface register model
`default_nettype none

package acia_pkg;

    localparam logic [2:0] CMD_CTRL_WR   = 3'd0;
    localparam logic [2:0] CMD_TX_WR     = 3'd1;
    localparam logic [2:0] CMD_STAT_RD   = 3'd2;
    localparam logic [2:0] CMD_RX_RD     = 3'd3;
    localparam logic [2:0] CMD_LINE_BYTE = 3'd4;
    localparam logic [2:0] CMD_PROC_WR   = 3'd5;
    localparam logic [2:0] CMD_PROC_RD   = 3'd6;
    localparam logic [2:0] CMD_POLL      = 3'd7;

    localparam logic [7:0] SEVEN_MASK   = 8'd127;
    localparam logic [7:0] RTS_TIE_BITS = 8'd96;
    localparam logic [7:0] RELAY_BIT    = 8'd128;
    localparam logic [7:0] CH_RS423_BIT = 8'h40;

    localparam int STAT_RX_FULL  = 0;
    localparam int STAT_TX_EMPTY = 1;
    localparam int STAT_CTS      = 3;
    localparam int STAT_OVERRUN  = 5;
    localparam int STAT_IRQ      = 7;

    typedef struct packed {
        logic [2:0] command;
        logic [7:0] data;
    } t_item;

    typedef struct packed {
        logic       rts_line;
        logic       relay_click;
        logic       motor_relay;
        logic [7:0] tx_byte;
        logic       tx_valid;
        logic       irq;
        logic [7:0] read_data;
    } t_result;

endpackage

`default_nettype wire

/* design/acia_in_reg.sv */
// input register stage holding one accepted item
`default_nettype none

module acia_in_reg (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    input  wire acia_pkg::t_item i_item,
    input  wire                  i_advance,
    output logic                 o_ready,
    output logic                 o_valid,
    output acia_pkg::t_item      o_item
);
    import acia_pkg::*;

    logic  r_vld;
    t_item r_item;

    assign o_ready = !r_vld || i_advance;
    assign o_valid = r_vld;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

`default_nettype wire

/* design/acia_core.sv */
// register state and single-pass command decode
`default_nettype none

module acia_core (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_en,
    input  wire acia_pkg::t_item i_item,
    output acia_pkg::t_result    o_res
);
    import acia_pkg::*;

    logic [7:0] r_status, n_status;
    logic [7:0] r_serproc, n_serproc;
    logic [7:0] r_rx_hold, n_rx_hold;
    logic [7:0] r_rx_shift, n_rx_shift;
    logic [1:0] r_rx_fill, n_rx_fill;
    logic       r_first_rst, n_first_rst;
    logic       r_rts, n_rts;
    logic       r_rx_ie, n_rx_ie;
    logic       r_seven, n_seven;
    logic       r_irq, n_irq;
    logic       r_last_relay, n_last_relay;

    logic [7:0] rd;
    logic       txv;
    logic [7:0] txb;
    logic       click;
    logic [1:0] fill_dec;
    logic [7:0] d;

    always_comb begin
        d            = i_item.data;
        n_status     = r_status;
        n_serproc    = r_serproc;
        n_rx_hold    = r_rx_hold;
        n_rx_shift   = r_rx_shift;
        n_rx_fill    = r_rx_fill;
        n_first_rst  = r_first_rst;
        n_rts        = r_rts;
        n_rx_ie      = r_rx_ie;
        n_seven      = r_seven;
        n_irq        = r_irq;
        n_last_relay = r_last_relay;
        rd           = 8'd0;
        txv          = 1'b0;
        txb          = 8'd0;
        click        = 1'b0;
        fill_dec     = (r_rx_fill == 2'd3) ? 2'd2 : r_rx_fill;
        case (i_item.command)
            CMD_CTRL_WR: begin
                if (d[1:0] == 2'b11) begin
                    n_status = (r_status & 8'h08) | 8'h02;
                    n_irq    = 1'b0;
                    if (r_first_rst) begin
                        n_status[STAT_CTS] = 1'b1;
                        n_first_rst        = 1'b0;
                    end
                end
                n_seven = !d[4];
                n_rx_ie = d[7];
                n_rts   = ((d & RTS_TIE_BITS) == RTS_TIE_BITS) ? 1'b0 : d[6];
            end
            CMD_TX_WR: begin
                n_irq              = 1'b0;
                n_status[STAT_IRQ] = 1'b0;
                if ((r_serproc & CH_RS423_BIT) != 8'd0) begin
                    txv = 1'b1;
                    txb = d;
                end
            end
            CMD_STAT_RD: begin
                rd = r_status;
            end
            CMD_RX_RD: begin
                n_irq              = 1'b0;
                n_status[STAT_IRQ] = 1'b0;
                rd                 = r_seven ? (r_rx_hold & SEVEN_MASK) : r_rx_hold;
                n_rx_hold          = r_rx_shift;
                n_rx_shift         = 8'd0;
                if (fill_dec != 2'd0) begin
                    fill_dec = fill_dec - 2'd1;
                end
                n_rx_fill = fill_dec;
                if (fill_dec == 2'd0) begin
                    n_status[STAT_RX_FULL] = 1'b0;
                end else if (r_rx_ie) begin
                    n_irq              = 1'b1;
                    n_status[STAT_IRQ] = 1'b1;
                end
            end
            CMD_LINE_BYTE: begin
                n_status[STAT_OVERRUN] = 1'b0;
                if (r_rx_fill == 2'd0) begin
                    n_rx_hold              = d;
                    n_status[STAT_RX_FULL] = 1'b1;
                    n_rx_fill              = 2'd1;
                end else if (r_rx_fill == 2'd1) begin
                    n_rx_shift             = d;
                    n_status[STAT_RX_FULL] = 1'b1;
                    n_rx_fill              = 2'd2;
                end else begin
                    n_rx_hold              = r_rx_shift;
                    n_rx_shift             = d;
                    n_status[STAT_OVERRUN] = 1'b1;
                    n_rx_fill              = 2'd2;
                end
                if (r_rx_ie) begin
                    n_irq              = 1'b1;
                    n_status[STAT_IRQ] = 1'b1;
                end
            end
            CMD_PROC_WR: begin
                n_serproc = d;
                if (d[7] != r_last_relay) begin
                    click        = 1'b1;
                    n_last_relay = d[7];
                end
            end
            CMD_PROC_RD: begin
                rd = r_serproc;
            end
            CMD_POLL: begin
                if ((r_serproc & CH_RS423_BIT) != 8'd0) begin
                    n_status[STAT_CTS] = 1'b1;
                end
            end
            default: begin
                rd = 8'd0;
            end
        endcase
    end

    assign o_res.read_data   = rd;
    assign o_res.irq         = n_irq;
    assign o_res.tx_valid    = txv;
    assign o_res.tx_byte     = txb;
    assign o_res.motor_relay = (n_serproc & RELAY_BIT) != 8'd0;
    assign o_res.relay_click = click;
    assign o_res.rts_line    = n_rts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status     <= 8'd0;
            r_serproc    <= 8'd0;
            r_rx_hold    <= 8'd0;
            r_rx_shift   <= 8'd0;
            r_rx_fill    <= 2'd0;
            r_first_rst  <= 1'b1;
            r_rts        <= 1'b0;
            r_rx_ie      <= 1'b0;
            r_seven      <= 1'b0;
            r_irq        <= 1'b0;
            r_last_relay <= 1'b0;
        end else if (i_en) begin
            r_status     <= n_status;
            r_serproc    <= n_serproc;
            r_rx_hold    <= n_rx_hold;
            r_rx_shift   <= n_rx_shift;
            r_rx_fill    <= n_rx_fill;
            r_first_rst  <= n_first_rst;
            r_rts        <= n_rts;
            r_rx_ie      <= n_rx_ie;
            r_seven      <= n_seven;
            r_irq        <= n_irq;
            r_last_relay <= n_last_relay;
        end
    end

endmodule

`default_nettype wire

/* design/acia_serial_register_model_core.sv */
// top level: input register, command decode and result register
// an accepted item passes through the input register, then the result register
// throughput: one item per cycle unless stalled; single-pass decode between the two registers
// a stalled result register holds its item while the input register still takes one more
// reset: synchronous active low; clears both valid flags and all register state,
// first master reset pending is set
`default_nettype none

module acia_serial_register_model_core (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [7:0]  i_s_tdata,   // data[7:0]
    input  wire  [2:0]  i_s_tuser,   // command[2:0]
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [23:0] o_m_tdata    // read_data[7:0], irq[8], tx_valid[9], tx_byte[17:10],
                                     // motor_relay[18], relay_click[19], rts_line[20], zero[23:21]
);
    import acia_pkg::*;

    t_item   in_item;
    t_item   stage_item;
    logic    stage_vld;
    logic    advance;
    t_result core_res;
    t_result r_res;
    logic    r_out_vld;

    assign in_item.command = i_s_tuser;
    assign in_item.data    = i_s_tdata;
    assign advance         = stage_vld && (!r_out_vld || i_m_tready);

    acia_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_tvalid),
        .i_item    (in_item),
        .i_advance (advance),
        .o_ready   (o_s_tready),
        .o_valid   (stage_vld),
        .o_item    (stage_item)
    );

    acia_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_item  (stage_item),
        .o_res   (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res <= core_res;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {3'd0, r_res};

    a_adv_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> o_m_tvalid)
        else $error("decoded item did not reach the result register");

    a_accept_fills_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> stage_vld)
        else $error("accepted item lost before the decode stage");

    a_tx_only_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && r_res.tx_valid) |-> (r_res.read_data == 8'd0 && !r_res.relay_click))
        else $error("transmit result mixed with read or relay result");

endmodule

`default_nettype wire
